FILE: sv/dbdh_pkg.sv
// ----------------------------------------------------------------------------
// dbdh_pkg
// Shared types and constants for the dual button debouncer with hold events.
// ----------------------------------------------------------------------------
package dbdh_pkg;

  localparam int unsigned STABLE_W = 8;
  localparam int unsigned HOLD_W   = 15;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam logic [STABLE_W-1:0] PRESS_STABLE_RESET   = 8'd2;
  localparam logic [STABLE_W-1:0] RELEASE_STABLE_RESET = 8'd20;
  localparam logic [HOLD_W-1:0]   HOLD_TICKS_RESET     = 15'd600;
  localparam logic [HOLD_W-1:0]   HOLD_COUNT_RESET     = 15'd1000;

  // Register indexes (word address bits [3:2])
  typedef enum logic [1:0] {
    REG_PRESS_STABLE   = 2'd0,
    REG_RELEASE_STABLE = 2'd1,
    REG_HOLD_TICKS     = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    EV_BOTH_OFF   = 4'd0,
    EV_LEFT_ON    = 4'd1,
    EV_LEFT_OFF   = 4'd2,
    EV_RIGHT_ON   = 4'd3,
    EV_RIGHT_OFF  = 4'd4,
    EV_LEFT_HOLD  = 4'd5,
    EV_RIGHT_HOLD = 4'd6,
    EV_BOTH_ON    = 4'd7,
    EV_BOTH_HOLD  = 4'd8
  } event_t;

  typedef struct packed {
    logic left_raw;
    logic right_raw;
  } in_beat_t;

  typedef struct packed {
    event_t event_code;
    logic   left_level;
    logic   right_level;
  } out_beat_t;

  typedef struct packed {
    logic [STABLE_W-1:0] press_stable_ticks;
    logic [STABLE_W-1:0] release_stable_ticks;
    logic [HOLD_W-1:0]   hold_ticks;
  } cfg_t;

  // One button's debounce outcome for the current tick
  typedef struct packed {
    logic                changed;
    logic                level;
    logic [STABLE_W-1:0] stable;
    logic                steady_pressed;
  } deb_t;

endpackage

FILE: sv/dbdh_apb_regs.sv
// ----------------------------------------------------------------------------
// dbdh_apb_regs
// APB register file: stability times and hold time.
// ----------------------------------------------------------------------------
module dbdh_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbdh_pkg::ADDR_W-1:0]   paddr,
  input  logic [dbdh_pkg::DATA_W-1:0]   pwdata,
  output logic [dbdh_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dbdh_pkg::cfg_t                cfg
);

  logic                          wr_en;
  dbdh_pkg::reg_index_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = dbdh_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_stable_ticks   <= dbdh_pkg::PRESS_STABLE_RESET;
      cfg.release_stable_ticks <= dbdh_pkg::RELEASE_STABLE_RESET;
      cfg.hold_ticks           <= dbdh_pkg::HOLD_TICKS_RESET;
    end else if (wr_en) begin
      case (idx)
        dbdh_pkg::REG_PRESS_STABLE:
          cfg.press_stable_ticks <= pwdata[dbdh_pkg::STABLE_W-1:0];
        dbdh_pkg::REG_RELEASE_STABLE:
          cfg.release_stable_ticks <= pwdata[dbdh_pkg::STABLE_W-1:0];
        dbdh_pkg::REG_HOLD_TICKS:
          cfg.hold_ticks <= pwdata[dbdh_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dbdh_pkg::REG_PRESS_STABLE:
        prdata = {{(dbdh_pkg::DATA_W-dbdh_pkg::STABLE_W){1'b0}}, cfg.press_stable_ticks};
      dbdh_pkg::REG_RELEASE_STABLE:
        prdata = {{(dbdh_pkg::DATA_W-dbdh_pkg::STABLE_W){1'b0}}, cfg.release_stable_ticks};
      dbdh_pkg::REG_HOLD_TICKS:
        prdata = {{(dbdh_pkg::DATA_W-dbdh_pkg::HOLD_W){1'b0}}, cfg.hold_ticks};
      default:
        prdata = '0;
    endcase
  end

endmodule

FILE: sv/dbdh_debounce.sv
// ----------------------------------------------------------------------------
// dbdh_debounce
// Stability countdown and level acceptance for one button.
// ----------------------------------------------------------------------------
module dbdh_debounce (
  input  logic                          raw,
  input  logic                          level,
  input  logic [dbdh_pkg::STABLE_W-1:0] stable,
  input  dbdh_pkg::cfg_t                cfg,
  output dbdh_pkg::deb_t                deb
);

  logic [dbdh_pkg::STABLE_W-1:0] dec;

  assign dec = stable - dbdh_pkg::STABLE_W'(1);

  always_comb begin
    deb.changed        = 1'b0;
    deb.level          = level;
    deb.steady_pressed = 1'b0;
    if (raw == level) begin
      // reload with the time the opposite transition must persist
      deb.steady_pressed = level;
      deb.stable = level ? cfg.release_stable_ticks : cfg.press_stable_ticks;
    end else if (dec != '0) begin
      deb.stable = dec;
    end else begin
      deb.changed = 1'b1;
      deb.level   = raw;
      deb.stable  = raw ? cfg.release_stable_ticks : cfg.press_stable_ticks;
    end
  end

endmodule

FILE: sv/dbdh_core.sv
// ----------------------------------------------------------------------------
// dbdh_core
// Button state, hold counters and event classifier; one tick per step.
// ----------------------------------------------------------------------------
module dbdh_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  dbdh_pkg::in_beat_t  in_beat,
  input  dbdh_pkg::cfg_t      cfg,
  output logic                res_valid,
  output dbdh_pkg::out_beat_t res_beat
);

  logic                          left_debounced, right_debounced;
  logic [dbdh_pkg::STABLE_W-1:0] left_stable_count, right_stable_count;
  logic [dbdh_pkg::HOLD_W-1:0]   left_hold_count, right_hold_count;
  dbdh_pkg::event_t              last_event;

  dbdh_pkg::deb_t                ldeb, rdeb;
  logic [dbdh_pkg::HOLD_W-1:0]   lh1, rh1, left_hold_next, right_hold_next;
  logic                          lz, rz, l, r, consider, suppress;
  dbdh_pkg::event_t              last_event_next;

  dbdh_debounce u_left (
    .raw    (in_beat.left_raw),
    .level  (left_debounced),
    .stable (left_stable_count),
    .cfg    (cfg),
    .deb    (ldeb)
  );

  dbdh_debounce u_right (
    .raw    (in_beat.right_raw),
    .level  (right_debounced),
    .stable (right_stable_count),
    .cfg    (cfg),
    .deb    (rdeb)
  );

  // Left is handled fully before right: a left change reloads both counters,
  // then the right button may still count its own counter down.
  always_comb begin
    if (ldeb.changed) begin
      lh1 = cfg.hold_ticks;
      rh1 = cfg.hold_ticks;
    end else begin
      lh1 = (ldeb.steady_pressed && left_hold_count != '0) ?
            left_hold_count - dbdh_pkg::HOLD_W'(1) : left_hold_count;
      rh1 = right_hold_count;
    end
    if (rdeb.changed) begin
      left_hold_next  = cfg.hold_ticks;
      right_hold_next = cfg.hold_ticks;
    end else begin
      left_hold_next  = lh1;
      right_hold_next = (rdeb.steady_pressed && rh1 != '0) ?
                        rh1 - dbdh_pkg::HOLD_W'(1) : rh1;
    end
  end

  assign lz = (left_hold_next == '0);
  assign rz = (right_hold_next == '0);
  assign l  = ldeb.level;
  assign r  = rdeb.level;

  assign consider = ldeb.changed || rdeb.changed || lz || rz;
  assign suppress = (lz && rz && last_event == dbdh_pkg::EV_BOTH_HOLD) ||
                    (lz && last_event == dbdh_pkg::EV_LEFT_HOLD) ||
                    (rz && last_event == dbdh_pkg::EV_RIGHT_HOLD);
  assign res_valid = consider && !suppress;

  always_comb begin
    priority if (ldeb.changed && l && !r)     last_event_next = dbdh_pkg::EV_LEFT_ON;
    else if (ldeb.changed && !l)              last_event_next = dbdh_pkg::EV_LEFT_OFF;
    else if (rdeb.changed && !l && r)         last_event_next = dbdh_pkg::EV_RIGHT_ON;
    else if (rdeb.changed && !r)              last_event_next = dbdh_pkg::EV_RIGHT_OFF;
    else if (lz && l && !r)                   last_event_next = dbdh_pkg::EV_LEFT_HOLD;
    else if (rz && !l && r)                   last_event_next = dbdh_pkg::EV_RIGHT_HOLD;
    else if (lz && rz && l && r)              last_event_next = dbdh_pkg::EV_BOTH_HOLD;
    else if ((ldeb.changed || rdeb.changed) && l && r)
                                              last_event_next = dbdh_pkg::EV_BOTH_ON;
    else                                      last_event_next = last_event;  // resend
  end

  assign res_beat.event_code  = last_event_next;
  assign res_beat.left_level  = l;
  assign res_beat.right_level = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_debounced     <= 1'b0;
      right_debounced    <= 1'b0;
      left_stable_count  <= dbdh_pkg::PRESS_STABLE_RESET;
      right_stable_count <= dbdh_pkg::PRESS_STABLE_RESET;
      left_hold_count    <= dbdh_pkg::HOLD_COUNT_RESET;
      right_hold_count   <= dbdh_pkg::HOLD_COUNT_RESET;
      last_event         <= dbdh_pkg::EV_BOTH_OFF;
    end else if (step) begin
      left_debounced     <= ldeb.level;
      right_debounced    <= rdeb.level;
      left_stable_count  <= ldeb.stable;
      right_stable_count <= rdeb.stable;
      left_hold_count    <= left_hold_next;
      right_hold_count   <= right_hold_next;
      if (res_valid) begin
        last_event <= last_event_next;
      end
    end
  end

  // State moves only on a tick
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(left_hold_count) && $stable(right_hold_count) &&
              $stable(left_debounced) && $stable(right_debounced) &&
              $stable(last_event))
    else $error("button state changed without a tick");

  // An accepted right change reloads both hold counters
  a_right_reload: assert property (@(posedge clk) disable iff (rst)
    step && rdeb.changed |=> left_hold_count == right_hold_count)
    else $error("hold counters differ after right change");

  // No result goes out while the left hold event is repeated
  a_hold_once: assert property (@(posedge clk) disable iff (rst)
    step && lz && last_event == dbdh_pkg::EV_LEFT_HOLD |-> !res_valid)
    else $error("repeated left hold event");

endmodule

FILE: sv/dual_button_debounce_hold.sv
// ----------------------------------------------------------------------------
// dual_button_debounce_hold
// Two-button debouncer with press, release and long-press event reporting.
// ----------------------------------------------------------------------------
// Takes one beat of raw left/right samples per scan tick, one beat per clock
// when both sides keep up. A beat is held in an input register, the debounce
// and classification logic is combinational, and a result (zero or one per
// tick) lands in the output register. The input register doubles as a skid
// stage: one further beat is taken while a result waits under stall.
// Register writes are to be made only while the block is idle.
// ----------------------------------------------------------------------------
module dual_button_debounce_hold (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dbdh_pkg::in_beat_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dbdh_pkg::out_beat_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dbdh_pkg::ADDR_W-1:0]  paddr,
  input  logic [dbdh_pkg::DATA_W-1:0]  pwdata,
  output logic [dbdh_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  dbdh_pkg::cfg_t      cfg;
  logic                in_reg_valid;
  dbdh_pkg::in_beat_t  in_reg;
  logic                adv;
  logic                step;
  logic                res_valid;
  dbdh_pkg::out_beat_t res_beat;

  dbdh_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Output register free or being drained this cycle
  assign adv      = !out_valid || !out_stall;
  assign step     = in_reg_valid && adv;
  assign in_stall = in_reg_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_reg_valid || adv) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_reg_valid || adv) begin
      in_reg <= in_data;
    end
  end

  dbdh_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_beat   (in_reg),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_beat  (res_beat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_data <= res_beat;
    end
  end

  // Hold the buffered beat while the output is blocked
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !adv |=> in_reg_valid && $stable(in_reg))
    else $error("buffered input beat lost under stall");

  // A result leaves only when taken
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped while stalled");

endmodule
